### design/ecfe_pkg.sv
// Shared types, constants and CRC helper for the escaped CRC frame encoder.
// Used by all design modules except the checker; depends on nothing.

package ecfe_pkg;

	// line codes
	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	// candidate output slots of one input word, in line order
	localparam int unsigned NUM_SLOTS     = 8;
	localparam int unsigned SLOT_OPEN     = 0;
	localparam int unsigned SLOT_DATA     = 1;
	localparam int unsigned SLOT_DATA_ESC = 2;
	localparam int unsigned SLOT_CRC_HI   = 3;
	localparam int unsigned SLOT_HI_ESC   = 4;
	localparam int unsigned SLOT_CRC_LO   = 5;
	localparam int unsigned SLOT_LO_ESC   = 6;
	localparam int unsigned SLOT_CLOSE    = 7;

	typedef logic [NUM_SLOTS-1:0] slot_mask_t;

	// bytes of all candidate slots plus which of them go out
	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] bytes;
		slot_mask_t                mask;
	} slot_set_t;

	// one byte through the CRC, MSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// byte that needs a trailing escape
	function automatic logic is_special(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

endpackage

### design/ecfe_in_if.sv
// Input channel of the frame encoder: one raw payload word per handshake.
// Stands alone; no package needed.

interface ecfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_frame;

	modport source (output valid, output data_byte, output end_of_frame, input ready);
	modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

### design/ecfe_out_if.sv
// Output channel of the frame encoder: one encoded line word per handshake.
// Stands alone; no package needed.

interface ecfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;

	modport source (output valid, output out_byte, output last_out, input ready);
	modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

### design/ecfe_slot_build.sv
// Builds the candidate output slots of one payload word and the next CRC.
// Depends on ecfe_pkg.

module ecfe_slot_build (
	input  logic [7:0]        data_byte,
	input  logic              end_of_frame,
	input  logic [15:0]       crc,
	input  logic              frame_open,
	output ecfe_pkg::slot_set_t slots,
	output logic [15:0]       crc_next
);

	logic [15:0] crc_upd;

	assign crc_upd  = ecfe_pkg::crc_feed(crc, data_byte);
	// frame end restarts the CRC for the next frame
	assign crc_next = end_of_frame ? ecfe_pkg::CRC_INIT : crc_upd;

	// slot bytes and which slots are sent
	always_comb begin
		slots.bytes[ecfe_pkg::SLOT_OPEN]     = ecfe_pkg::FLAG_BYTE;
		slots.bytes[ecfe_pkg::SLOT_DATA]     = data_byte;
		slots.bytes[ecfe_pkg::SLOT_DATA_ESC] = ecfe_pkg::ESC_BYTE;
		slots.bytes[ecfe_pkg::SLOT_CRC_HI]   = crc_upd[15:8];
		slots.bytes[ecfe_pkg::SLOT_HI_ESC]   = ecfe_pkg::ESC_BYTE;
		slots.bytes[ecfe_pkg::SLOT_CRC_LO]   = crc_upd[7:0];
		slots.bytes[ecfe_pkg::SLOT_LO_ESC]   = ecfe_pkg::ESC_BYTE;
		slots.bytes[ecfe_pkg::SLOT_CLOSE]    = ecfe_pkg::FLAG_BYTE;

		slots.mask[ecfe_pkg::SLOT_OPEN]     = !frame_open;
		slots.mask[ecfe_pkg::SLOT_DATA]     = 1'b1;
		slots.mask[ecfe_pkg::SLOT_DATA_ESC] = ecfe_pkg::is_special(data_byte);
		slots.mask[ecfe_pkg::SLOT_CRC_HI]   = end_of_frame;
		slots.mask[ecfe_pkg::SLOT_HI_ESC]   = end_of_frame && ecfe_pkg::is_special(crc_upd[15:8]);
		slots.mask[ecfe_pkg::SLOT_CRC_LO]   = end_of_frame;
		slots.mask[ecfe_pkg::SLOT_LO_ESC]   = end_of_frame && ecfe_pkg::is_special(crc_upd[7:0]);
		slots.mask[ecfe_pkg::SLOT_CLOSE]    = end_of_frame;
	end

endmodule

### design/ecfe_serializer.sv
// Holds the slots of one payload word and sends the enabled ones, one word
// per unstalled cycle, lowest slot first. Depends on ecfe_pkg, ecfe_out_if.

module ecfe_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ecfe_pkg::slot_set_t slots,
	output logic                free,
	ecfe_out_if.source          out_ch
);

	ecfe_pkg::slot_mask_t                       mask_q;
	logic [ecfe_pkg::NUM_SLOTS-1:0][7:0]        bytes_q;
	ecfe_pkg::slot_mask_t                       pick;
	logic                                       last;
	logic                                       take;

	// lowest pending slot
	assign pick = mask_q & (~mask_q + ecfe_pkg::slot_mask_t'(1));
	assign last = (mask_q & ~pick) == '0;
	assign take = out_ch.valid && out_ch.ready;
	assign free = (mask_q == '0) || (take && last);

	assign out_ch.valid    = mask_q != '0;
	assign out_ch.last_out = last;

	// one-hot select of the outgoing byte
	always_comb begin
		out_ch.out_byte = '0;
		for (int i = 0; i < ecfe_pkg::NUM_SLOTS; i++) begin
			out_ch.out_byte = out_ch.out_byte | (bytes_q[i] & {8{pick[i]}});
		end
	end

	// pending mask: load a new word or retire the sent slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= slots.mask;
		end else if (take) begin
			mask_q <= mask_q & ~pick;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= slots.bytes;
		end
	end

endmodule

### design/escaped_crc_frame_encoder.sv
// Byte-stuffed frame encoder with CRC-16/CCITT-FALSE. Each payload word
// yields 1 to 8 line words: an opening 0x7E on the first word of a frame,
// the data byte, and on the end_of_frame word the CRC high and low bytes and
// a closing 0x7E; any data or CRC byte equal to 0x7E or 0x7D is followed by
// a 0x7D. The output sends one word per cycle while out_ch.ready is high,
// so an input word holds the output until all its words are sent (2 words
// for a plain mid-frame byte with its escape, 1 without; up to 8 on a frame
// end); the input is accepted every cycle the output keeps up. An accepted
// word passes the one-word input register, then the serializer's output
// register. Depends on ecfe_pkg, ecfe_in_if, ecfe_out_if.

module escaped_crc_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	ecfe_in_if.sink    in_ch,
	ecfe_out_if.source out_ch
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                eof_s1;
	logic [15:0]         crc_q;
	logic                open_q;
	logic                ser_free;
	logic                load;
	logic [15:0]         crc_next;
	ecfe_pkg::slot_set_t slots;

	assign load        = valid_s1 && ser_free;
	assign in_ch.ready = !valid_s1 || ser_free;

	// input register and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			crc_q    <= ecfe_pkg::CRC_INIT;
			open_q   <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (load) begin
				crc_q  <= crc_next;
				open_q <= !eof_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			eof_s1  <= in_ch.end_of_frame;
		end
	end

	ecfe_slot_build u_build (
		.data_byte    (data_s1),
		.end_of_frame (eof_s1),
		.crc          (crc_q),
		.frame_open   (open_q),
		.slots        (slots),
		.crc_next     (crc_next)
	);

	ecfe_serializer u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.slots  (slots),
		.free   (ser_free),
		.out_ch (out_ch)
	);

endmodule

### design/ecfe_checker.sv
// Port-level checks for the frame encoder, bound to its top level.
// Depends on the top level escaped_crc_frame_encoder only.

module ecfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output word changed while stalled");

	// input only stalls behind pending output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with output idle");

	// a word accepted with output idle passes input and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid)
		else $error("accepted word did not reach output");

endmodule

bind escaped_crc_frame_encoder ecfe_checker u_ecfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.last_out)
);

### test/escaped_crc_frame_encoder_tb.sv
// Self-checking testbench for the escaped CRC frame encoder: drives payload
// words, predicts the stuffed line words with CRC and checks every one.
// Depends on ecfe_pkg, ecfe_in_if, ecfe_out_if and the encoder itself.
`timescale 1ns / 100ps

module escaped_crc_frame_encoder_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;
	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} line_word_t;

	logic clk;
	logic arst_n;

	ecfe_in_if  in_ch ();
	ecfe_out_if out_ch ();

	escaped_crc_frame_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state
	logic [15:0] frame_crc;
	logic        frame_open;
	line_word_t  line_expect_q [$];

	// run control and bookkeeping
	logic src_idle_on;
	logic sink_idle_on;
	int   sink_hold_len;
	logic sink_holding;
	int   n_words;
	int   n_frames;
	int   n_checked;
	int   n_errors;
	int   stall_cycles;
	line_word_t exp_word;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// CRC-16/CCITT-FALSE, one input bit at a time
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[15] ^ d[i];
			r  = {r[14:0], 1'b0};
			if (fb)
				r = r ^ ecfe_pkg::CRC_POLY;
		end
		return r;
	endfunction

	function automatic logic escaped_byte(input logic [7:0] b);
		return (b == ecfe_pkg::FLAG_BYTE) || (b == ecfe_pkg::ESC_BYTE);
	endfunction

	// expected line words for one accepted payload word
	task automatic predict_line_words(input logic [7:0] d, input logic eof);
		logic [7:0] seq [0:7];
		int         n;
		line_word_t w;
		n = 0;
		if (!frame_open) begin
			seq[n] = ecfe_pkg::FLAG_BYTE; n++;
			frame_open = 1'b1;
		end
		seq[n] = d; n++;
		if (escaped_byte(d)) begin
			seq[n] = ecfe_pkg::ESC_BYTE; n++;
		end
		frame_crc = crc16_step(frame_crc, d);
		if (eof) begin
			seq[n] = frame_crc[15:8]; n++;
			if (escaped_byte(frame_crc[15:8])) begin
				seq[n] = ecfe_pkg::ESC_BYTE; n++;
			end
			seq[n] = frame_crc[7:0]; n++;
			if (escaped_byte(frame_crc[7:0])) begin
				seq[n] = ecfe_pkg::ESC_BYTE; n++;
			end
			seq[n] = ecfe_pkg::FLAG_BYTE; n++;
			frame_crc  = ecfe_pkg::CRC_INIT;
			frame_open = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			w.code = seq[i];
			w.last = (i == n - 1);
			line_expect_q.push_back(w);
		end
	endtask

	// one payload word through the input handshake
	task automatic send_word(input logic [7:0] d, input logic eof);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        = 1'b1;
		in_ch.data_byte    = d;
		in_ch.end_of_frame = eof;
		do @(posedge clk); while (!in_ch.ready);
		predict_line_words(d, eof);
		n_words++;
		if (eof)
			n_frames++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// payload byte with the line codes well represented
	function automatic logic [7:0] random_payload_byte();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return ecfe_pkg::FLAG_BYTE;
		if (r == 1)
			return ecfe_pkg::ESC_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_random_frame(input int max_len);
		int len;
		len = $urandom_range(1, max_len);
		for (int i = 0; i < len; i++)
			send_word(random_payload_byte(), i == len - 1);
	endtask

	// two lead bytes that make the CRC of {a, b, tail} need the wanted escapes
	function automatic logic [16:0] find_crc_lead(input logic [7:0] tail,
			input logic want_hi, input logic want_lo);
		logic [15:0] c;
		for (int a = 0; a < 256; a++) begin
			for (int b = 0; b < 256; b++) begin
				c = crc16_step(crc16_step(crc16_step(ecfe_pkg::CRC_INIT, a[7:0]), b[7:0]),
					tail);
				if (escaped_byte(c[15:8]) == want_hi && escaped_byte(c[7:0]) == want_lo)
					return {1'b1, a[7:0], b[7:0]};
			end
		end
		return 17'd0;
	endfunction

	task automatic send_crc_escape_frame(input logic [7:0] tail, input logic want_hi,
			input logic want_lo);
		logic [16:0] hit;
		hit = find_crc_lead(tail, want_hi, want_lo);
		if (!hit[16])
			hit = find_crc_lead(tail, 1'b1, 1'b0);
		send_word(hit[15:8], 1'b0);
		send_word(hit[7:0], 1'b0);
		send_word(tail, 1'b1);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
	endtask

	// single-byte frames, line codes in data, CRC bytes that need escapes
	task automatic test_directed();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(ecfe_pkg::FLAG_BYTE, 1'b1);
		send_word(ecfe_pkg::ESC_BYTE, 1'b1);
		send_word(ecfe_pkg::FLAG_BYTE, 1'b0);
		send_word(ecfe_pkg::ESC_BYTE, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'hFE, 1'b1);
		send_crc_escape_frame(ecfe_pkg::FLAG_BYTE, 1'b1, 1'b1);
		send_crc_escape_frame(8'h3C, 1'b1, 1'b0);
		send_crc_escape_frame(ecfe_pkg::ESC_BYTE, 1'b0, 1'b1);
	endtask

	// random frames, mostly short, with idling on both sides
	task automatic test_random_frames(input int words);
		int stop_at;
		stop_at      = n_words + words;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		while (n_words < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				send_random_frame(32);
			else
				send_random_frame(8);
		end
	endtask

	// receiver holds off while the sender keeps pushing
	task automatic test_backpressure(input int words);
		int stop_at;
		stop_at       = n_words + words;
		src_idle_on   = 1'b0;
		sink_idle_on  = 1'b0;
		sink_hold_len = LONG_HOLD;
		while (!sink_holding) @(negedge clk);
		while (n_words < stop_at)
			send_random_frame(12);
	endtask

	// back to back, no idling anywhere
	task automatic test_full_rate(input int words);
		int stop_at;
		stop_at      = n_words + words;
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		while (n_words < stop_at)
			send_random_frame(10);
	endtask

	// line receiver: random stalls and the long hold-off
	initial begin : line_sink
		int burst;
		out_ch.ready = 1'b0;
		sink_holding = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold_len > 0) begin
				out_ch.ready = 1'b0;
				sink_holding = 1'b1;
				repeat (sink_hold_len) @(negedge clk);
				sink_hold_len = 0;
				sink_holding  = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready = 1'b0;
				burst = $urandom_range(1, 14);
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// compare each accepted line word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (line_expect_q.size() == 0) begin
				report_mismatch("unexpected word", 8'h00, out_ch.out_byte);
			end else begin
				exp_word = line_expect_q.pop_front();
				n_checked++;
				if (out_ch.out_byte !== exp_word.code)
					report_mismatch("out_byte", exp_word.code, out_ch.out_byte);
				if (out_ch.last_out !== exp_word.last)
					report_mismatch("last_out", {7'd0, exp_word.last}, {7'd0, out_ch.last_out});
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// reset, test sequence, drain and verdict
	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.data_byte    = 8'h00;
		in_ch.end_of_frame = 1'b0;
		src_idle_on        = 1'b0;
		sink_idle_on       = 1'b0;
		sink_hold_len      = 0;
		frame_crc          = ecfe_pkg::CRC_INIT;
		frame_open         = 1'b0;
		n_words            = 0;
		n_frames           = 0;
		n_checked          = 0;
		n_errors           = 0;
		stall_cycles       = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_frames(200);
		test_backpressure(40);
		test_full_rate(100);

		while (line_expect_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d payload words in %0d frames, checked %0d line words",
			n_words, n_frames, n_checked);
		$display("Covered line-code escapes in data and CRC, random stalls and a long hold-off");
		if (n_errors == 0 && line_expect_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
